@@ design/uatx_pkg.sv @@
package uatx_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned BITCNT_W = 4;
	localparam logic [BITCNT_W-1:0] DATA_BITS = 4'd8;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_PUSH = 1'b1;

	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_START = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STOP  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_HOLD1 = 3'd4;
	localparam logic [PHASE_W-1:0] PH_HOLD2 = 3'd5;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] data_byte;
	} cmd_item_t;

	typedef struct packed {
		logic               tx_line;
		logic               push_accepted;
		logic               busy_res;
		logic [LEVEL_W-1:0] fifo_level;
	} res_item_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [BYTE_W-1:0] wdata;
	} fifo_ctl_t;

	typedef struct packed {
		logic               empty;
		logic               push_ok;
		logic               nonempty_next;
		logic [LEVEL_W-1:0] level_next;
	} fifo_stat_t;

	typedef struct packed {
		logic pop;
		logic line_next;
		logic active_next;
	} seq_stat_t;

endpackage

@@ design/uart_tx_even_parity_fifo.sv @@
// Serial transmitter, 8 data bits, even parity, a stop bit and then the line held
// high through PH_HOLD1 and PH_HOLD2, behind a byte fifo that holds up to
// FIFO_DEPTH-1 bytes (a push into a full fifo is refused and reported with
// push_accepted low). Each command item is either a push or one baud tick; every
// item gives exactly one result item carrying the line level, the push flag, busy
// and the fifo level (modulo 8) after that item. One item is accepted per clock
// cycle unless cmd_stall is high (res_stall back-pressure); it passes the input
// register, then the result register, and the whole update of the fifo and the
// frame sequencer happens as it moves from one to the other. The popped byte is
// read from the fifo memory into a register on the idle tick that starts a frame. The line is high out of reset.
module uart_tx_even_parity_fifo #(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  uatx_pkg::cmd_item_t   cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output uatx_pkg::res_item_t   res
);

	logic                        valid_s1;
	uatx_pkg::cmd_item_t         cmd_s1;
	logic                        valid_s2;
	uatx_pkg::res_item_t         res_s2;
	logic                        s2_free;
	logic                        adv;
	logic                        tick;
	uatx_pkg::fifo_ctl_t         fifo_ctl;
	uatx_pkg::fifo_stat_t        fifo_stat;
	uatx_pkg::seq_stat_t         seq_stat;
	logic [uatx_pkg::BYTE_W-1:0] rdata;
	uatx_pkg::res_item_t         res_d;

	assign s2_free   = !valid_s2 || !res_stall;
	assign adv       = valid_s1 && s2_free;
	assign cmd_stall = valid_s1 && !s2_free;
	assign tick      = adv && (cmd_s1.action == uatx_pkg::ACT_TICK);

	always_comb begin
		fifo_ctl.push  = adv && (cmd_s1.action == uatx_pkg::ACT_PUSH);
		fifo_ctl.pop   = seq_stat.pop;
		fifo_ctl.wdata = cmd_s1.data_byte;
	end

	uatx_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (fifo_ctl),
		.stat  (fifo_stat),
		.rdata (rdata)
	);

	uatx_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.fifo_empty(fifo_stat.empty),
		.rdata     (rdata),
		.stat      (seq_stat)
	);

	always_comb begin
		res_d.tx_line       = seq_stat.line_next;
		res_d.push_accepted = fifo_stat.push_ok;
		res_d.busy_res      = seq_stat.active_next || fifo_stat.nonempty_next;
		res_d.fifo_level    = fifo_stat.level_next;
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.push_accepted) |-> res.busy_res)
		else $error("stored byte but not busy");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && valid_s2))
		else $error("stall without held items");

	a_pop_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		seq_stat.pop |-> tick)
		else $error("pop outside a tick");
`endif

endmodule

@@ design/uatx_fifo.sv @@
module uatx_fifo #(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uatx_pkg::fifo_ctl_t           ctl,
	output uatx_pkg::fifo_stat_t          stat,
	output logic [uatx_pkg::BYTE_W-1:0]   rdata
);

	localparam int unsigned IW = $clog2(FIFO_DEPTH);
	localparam logic [IW-1:0] LAST = IW'(FIFO_DEPTH - 1);

	logic [uatx_pkg::BYTE_W-1:0] mem [FIFO_DEPTH];
	logic [uatx_pkg::BYTE_W-1:0] rdata_q;
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] count_next;
	logic          full;
	logic          do_push;

	assign full       = (count_q == LAST);
	assign do_push    = ctl.push && !full;
	assign count_next = do_push ? count_q + 1'b1 : (ctl.pop ? count_q - 1'b1 : count_q);

	always_comb begin
		stat.empty         = (count_q == '0);
		stat.push_ok       = do_push;
		stat.nonempty_next = (count_next != '0);
		stat.level_next    = uatx_pkg::LEVEL_W'(count_next);
	end

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= ctl.wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_next;
		end
	end

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from empty fifo");

	a_index_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_q == rd_q))
		else $error("fifo indices disagree with count");
`endif

endmodule

@@ design/uatx_seq.sv @@
module uatx_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic                        fifo_empty,
	input  logic [uatx_pkg::BYTE_W-1:0] rdata,
	output uatx_pkg::seq_stat_t         stat
);

	logic [uatx_pkg::PHASE_W-1:0]  phase_q;
	logic [uatx_pkg::PHASE_W-1:0]  phase_d;
	logic [uatx_pkg::BITCNT_W-1:0] bitcnt_q;
	logic [uatx_pkg::BITCNT_W-1:0] bitcnt_d;
	logic                          parity_q;
	logic                          parity_d;
	logic                          line_q;
	logic                          line_d;
	logic                          pop;
	logic                          data_bit;

	assign data_bit = rdata[bitcnt_q[2:0]];

	always_comb begin
		phase_d  = phase_q;
		bitcnt_d = bitcnt_q;
		parity_d = parity_q;
		line_d   = line_q;
		pop      = 1'b0;
		unique case (phase_q)
			uatx_pkg::PH_IDLE: begin
				if (!fifo_empty) begin
					pop      = 1'b1;
					bitcnt_d = '0;
					parity_d = 1'b0;
					line_d   = 1'b1;
					phase_d  = uatx_pkg::PH_START;
				end
			end
			uatx_pkg::PH_START: begin
				line_d  = 1'b0;
				phase_d = uatx_pkg::PH_DATA;
			end
			uatx_pkg::PH_DATA: begin
				if (bitcnt_q < uatx_pkg::DATA_BITS) begin
					line_d   = data_bit;
					parity_d = parity_q ^ data_bit;
					bitcnt_d = bitcnt_q + 1'b1;
				end else begin
					line_d  = parity_q;
					phase_d = uatx_pkg::PH_STOP;
				end
			end
			uatx_pkg::PH_STOP: begin
				line_d  = 1'b1;
				phase_d = uatx_pkg::PH_HOLD1;
			end
			uatx_pkg::PH_HOLD1: begin
				phase_d = uatx_pkg::PH_HOLD2;
			end
			default: begin
				phase_d = uatx_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.pop         = tick && pop;
		stat.line_next   = tick ? line_d : line_q;
		stat.active_next = tick ? (phase_d != uatx_pkg::PH_IDLE)
		                        : (phase_q != uatx_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= uatx_pkg::PH_IDLE;
			bitcnt_q <= '0;
			parity_q <= 1'b0;
			line_q   <= 1'b1;
		end else if (tick) begin
			phase_q  <= phase_d;
			bitcnt_q <= bitcnt_d;
			parity_q <= parity_d;
			line_q   <= line_d;
		end
	end

`ifndef ASSERT_OFF
	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == uatx_pkg::PH_IDLE) |-> line_q)
		else $error("line low while idle");

	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= uatx_pkg::DATA_BITS)
		else $error("bit count past data bits");
`endif

endmodule
